/* rtl/dcods_pkg.sv */
// ----------------------------------------------------------------------------
// dcods_pkg
// Types and constants shared by the DCO divider search block.
// ----------------------------------------------------------------------------
package dcods_pkg;

   // Divider unit sizing: widest numerator is fdco << 24 (66 bits),
   // widest divisor is the 38-bit RFREQ.
   localparam int NUM_W  = 66;
   localparam int DEN_W  = 38;
   localparam int QUOT_W = 38;
   localparam int CNT_W  = 7;

   // DCO window in Hz
   localparam logic [32:0] FDCO_LO = 33'd4850000000;
   localparam logic [32:0] FDCO_HI = 33'd5670000000;

   localparam logic [30:0] FOUT_RESET = 31'd156250000;

   // register indexes
   localparam logic CSR_FOUT = 1'b0;
   localparam logic CSR_REGS = 1'b1;

   localparam logic [2:0] HS_LAST = 3'd5;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_DIV   = 2'd1,
      STAT_ZERO_DIV = 2'd2,
      STAT_RF_OVF   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEC,
      ST_FDCO,
      ST_DIV1_GO,
      ST_DIV1_RUN,
      ST_XTAL,
      ST_SRCH_MUL,
      ST_SRCH_CMP,
      ST_DIV2_GO,
      ST_DIV2_RUN,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      MUL_DEC,
      MUL_FDCO,
      MUL_SRCH
   } mul_sel_type;

   typedef struct packed {
      logic done;
      logic ovf;
   } div_stat_type;

   // HS_DIV search order
   function automatic logic [3:0] hs_of(input logic [2:0] idx);
      logic [3:0] v;
      case (idx)
         3'd0: v = 4'd11;
         3'd1: v = 4'd9;
         3'd2: v = 4'd7;
         3'd3: v = 4'd6;
         3'd4: v = 4'd5;
         3'd5: v = 4'd4;
         default: v = 4'd4;
      endcase
      return v;
   endfunction

endpackage

/* rtl/dco_divider_search.sv */
// ----------------------------------------------------------------------------
// dco_divider_search
// Oscillator divider search and RFREQ calculation.
// ----------------------------------------------------------------------------
// One item is handled at a time. The time an item takes grows with the number
// of HS_DIV/N1 candidates tried (at most 6 * (N1_LIMIT/2 + 1)). It is set by
// the shared bit-serial divider (used for the crystal and for the new
// RFREQ) and by the candidate loop, which uses one shared multiplier and a
// compare step per candidate. A new item is accepted once the previous one
// has been handed to the result register, even while that result waits.
// Configuration: index 0 factory output frequency, index 1 factory regs 7..12.
// ----------------------------------------------------------------------------
module dco_divider_search import dcods_pkg::*; #(
   parameter int N1_LIMIT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [30:0] req_target_hz,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_hs_div_out,
   output logic [7:0]  rsp_n1_out,
   output logic [37:0] rsp_rfreq_out,
   output logic [31:0] rsp_xtal_hz,
   output logic [47:0] rsp_reg_image
);

   // configuration
   logic [30:0] fout_ff;
   logic [47:0] regs_ff;

   // sequencer
   state_type state_ff, state_in;

   // datapath
   logic [30:0]  target_ff, target_in;
   logic [41:0]  prod_ff, prod_in;
   logic [31:0]  xtal_ff, xtal_in;
   logic [2:0]   hs_idx_ff, hs_idx_in;
   logic [7:0]   n1_ff, n1_in;
   logic [10:0]  k_ff, k_in;
   logic         found_ff, found_in;
   logic [32:0]  best_ff, best_in;
   logic [3:0]   best_hs_ff, best_hs_in;
   logic [7:0]   best_n1_ff, best_n1_in;
   logic [37:0]  rf_ff, rf_in;
   status_type   stat_ff, stat_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   status_type   o_stat_ff, o_stat_in;
   logic [3:0]   o_hs_ff, o_hs_in;
   logic [7:0]   o_n1_ff, o_n1_in;
   logic [37:0]  o_rf_ff, o_rf_in;
   logic [31:0]  o_xtal_ff, o_xtal_in;
   logic [47:0]  o_img_ff, o_img_in;

   // factory decode
   logic [7:0]  r7, r8;
   logic [3:0]  f_hs;
   logic [7:0]  f_n1_raw, f_n1;
   logic [37:0] f_rfreq;

   assign r7       = regs_ff[47:40];
   assign r8       = regs_ff[39:32];
   assign f_hs     = {1'b0, r7[7:5]} + 4'd4;
   assign f_n1_raw = {1'b0, r7[4:0], r8[7:6]} + 8'd1;
   assign f_n1     = (f_n1_raw > 8'd1) ? {f_n1_raw[7:1], 1'b0} : f_n1_raw;
   assign f_rfreq  = regs_ff[37:0];

   // control from the state
   mul_sel_type mul_sel;
   logic        div_start;
   logic        out_load;

   // shared multiplier, 31 x 11
   logic [30:0] mul_a;
   logic [10:0] mul_b;
   logic [41:0] mul_p;

   always_comb begin
      case (mul_sel)
         MUL_DEC: begin
            mul_a = {27'd0, f_hs};
            mul_b = {3'd0, f_n1};
         end
         MUL_FDCO: begin
            mul_a = fout_ff;
            mul_b = prod_ff[10:0];
         end
         MUL_SRCH: begin
            mul_a = target_ff;
            mul_b = k_ff;
         end
         default: begin
            mul_a = target_ff;
            mul_b = k_ff;
         end
      endcase
   end

   assign mul_p = 42'(mul_a) * 42'(mul_b);

   // shared divider
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   div_stat_type      div_stat;
   logic [QUOT_W-1:0] div_quot;
   logic              wide;
   logic [NUM_W-1:0]  num1;
   logic [DEN_W-1:0]  den1;

   // fdco >= 2^36 drops four RFREQ bits to keep the numerator in range
   assign wide = prod_ff[41:36] != 6'd0;
   assign num1 = wide ? {prod_ff, 24'd0} : {2'd0, prod_ff[35:0], 28'd0};
   assign den1 = wide ? {4'd0, f_rfreq[37:4]} : f_rfreq;

   always_comb begin
      if (state_ff == ST_DIV2_GO) begin
         div_num = {5'd0, best_ff, 28'd0};
         div_den = {6'd0, xtal_ff};
      end else begin
         div_num = num1;
         div_den = den1;
      end
   end

   dcods_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // search step
   logic [3:0]  cur_hs;
   logic [7:0]  n1_step;
   logic [10:0] k_step;
   logic        over, lim, last_hs, in_win, take;
   logic        out_free;

   assign cur_hs   = hs_of(hs_idx_ff);
   assign n1_step  = (n1_ff == 8'd1) ? 8'd2 : n1_ff + 8'd2;
   assign k_step   = (n1_ff == 8'd1) ? k_ff + {7'd0, cur_hs}
                                     : k_ff + {6'd0, cur_hs, 1'b0};
   assign over     = prod_ff > 42'(FDCO_HI);
   assign lim      = {1'b0, n1_step} > 9'(N1_LIMIT);
   assign last_hs  = hs_idx_ff == HS_LAST;
   assign in_win   = !over && (prod_ff >= 42'(FDCO_LO));
   assign take     = in_win && (!found_ff || (prod_ff[32:0] < best_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DEC;
         ST_DEC:      state_in = ST_FDCO;
         ST_FDCO:     state_in = ST_DIV1_GO;
         ST_DIV1_GO:  state_in = (den1 == '0) ? ST_FIN : ST_DIV1_RUN;
         ST_DIV1_RUN: if (div_stat.done) state_in = ST_XTAL;
         ST_XTAL: begin
            if (xtal_ff == '0 || target_ff == '0) state_in = ST_FIN;
            else state_in = ST_SRCH_MUL;
         end
         ST_SRCH_MUL: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            if ((over || lim) && last_hs) begin
               state_in = (found_ff || take) ? ST_DIV2_GO : ST_FIN;
            end else begin
               state_in = ST_SRCH_MUL;
            end
         end
         ST_DIV2_GO:  state_in = ST_DIV2_RUN;
         ST_DIV2_RUN: if (div_stat.done) state_in = ST_FIN;
         ST_FIN:      if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      mul_sel   = MUL_SRCH;
      div_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE:    req_stall = 1'b0;
         ST_DEC:     mul_sel   = MUL_DEC;
         ST_FDCO:    mul_sel   = MUL_FDCO;
         ST_DIV1_GO: div_start = den1 != '0;
         ST_DIV2_GO: div_start = 1'b1;
         ST_FIN:     out_load  = out_free;
         default:    mul_sel   = MUL_SRCH;
      endcase
   end

   // datapath
   always_comb begin
      target_in  = target_ff;
      prod_in    = prod_ff;
      xtal_in    = xtal_ff;
      hs_idx_in  = hs_idx_ff;
      n1_in      = n1_ff;
      k_in       = k_ff;
      found_in   = found_ff;
      best_in    = best_ff;
      best_hs_in = best_hs_ff;
      best_n1_in = best_n1_ff;
      rf_in      = rf_ff;
      stat_in    = stat_ff;
      case (state_ff)
         ST_IDLE:     target_in = req_target_hz;
         ST_DEC:      prod_in = mul_p;
         ST_FDCO:     prod_in = mul_p;
         ST_DIV1_GO: begin
            stat_in = STAT_ZERO_DIV;
            xtal_in = '0;
         end
         ST_DIV1_RUN: begin
            if (div_stat.done) begin
               // saturate the crystal estimate to 32 bits
               xtal_in = (div_stat.ovf || div_quot[37:32] != 6'd0) ? '1 : div_quot[31:0];
            end
         end
         ST_XTAL: begin
            stat_in   = (xtal_ff == '0) ? STAT_ZERO_DIV : STAT_NO_DIV;
            hs_idx_in = 3'd0;
            n1_in     = 8'd1;
            k_in      = {7'd0, hs_of(3'd0)};
            found_in  = 1'b0;
         end
         ST_SRCH_MUL: prod_in = mul_p;
         ST_SRCH_CMP: begin
            if (take) begin
               found_in   = 1'b1;
               best_in    = prod_ff[32:0];
               best_hs_in = cur_hs;
               best_n1_in = n1_ff;
            end
            if (over || lim) begin
               if (!last_hs) begin
                  hs_idx_in = hs_idx_ff + 3'd1;
                  n1_in     = 8'd1;
                  k_in      = {7'd0, hs_of(hs_idx_ff + 3'd1)};
               end
            end else begin
               n1_in = n1_step;
               k_in  = k_step;
            end
         end
         ST_DIV2_RUN: begin
            if (div_stat.done) begin
               stat_in = div_stat.ovf ? STAT_RF_OVF : STAT_OK;
               rf_in   = div_quot;
            end
         end
         default: stat_in = stat_ff;
      endcase
   end

   // result register
   logic [7:0] n1m;
   assign n1m = best_n1_ff - 8'd1;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      o_stat_in    = o_stat_ff;
      o_hs_in      = o_hs_ff;
      o_n1_in      = o_n1_ff;
      o_rf_in      = o_rf_ff;
      o_xtal_in    = o_xtal_ff;
      o_img_in     = o_img_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         o_stat_in    = stat_ff;
         o_xtal_in    = (stat_ff == STAT_ZERO_DIV) ? 32'd0 : xtal_ff;
         if (stat_ff == STAT_OK || stat_ff == STAT_RF_OVF) begin
            o_hs_in = best_hs_ff;
            o_n1_in = best_n1_ff;
         end else begin
            o_hs_in = '0;
            o_n1_in = '0;
         end
         if (stat_ff == STAT_OK) begin
            o_rf_in  = rf_ff;
            o_img_in = {best_hs_ff[2:0] - 3'd4, n1m[6:2], n1m[1:0], rf_ff[37:0]};
         end else begin
            o_rf_in  = '0;
            o_img_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         fout_ff      <= FOUT_RESET;
         regs_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_FOUT: fout_ff <= csr_wdata[30:0];
               CSR_REGS: regs_ff <= csr_wdata;
               default:  regs_ff <= regs_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      prod_ff    <= prod_in;
      xtal_ff    <= xtal_in;
      hs_idx_ff  <= hs_idx_in;
      n1_ff      <= n1_in;
      k_ff       <= k_in;
      best_ff    <= best_in;
      best_hs_ff <= best_hs_in;
      best_n1_ff <= best_n1_in;
      rf_ff      <= rf_in;
      stat_ff    <= stat_in;
      o_stat_ff  <= o_stat_in;
      o_hs_ff    <= o_hs_in;
      o_n1_ff    <= o_n1_in;
      o_rf_ff    <= o_rf_in;
      o_xtal_ff  <= o_xtal_in;
      o_img_ff   <= o_img_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = o_stat_ff;
   assign rsp_hs_div_out = o_hs_ff;
   assign rsp_n1_out     = o_n1_ff;
   assign rsp_rfreq_out  = o_rf_ff;
   assign rsp_xtal_hz    = o_xtal_ff;
   assign rsp_reg_image  = o_img_ff;

`ifndef NO_ASSERTIONS
   a_best_in_window: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_ff >= FDCO_LO && best_ff <= FDCO_HI))
      else $error("kept candidate outside the DCO window");

   a_ok_dividers: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_OK) |->
      (rsp_hs_div_out >= 4'd4 && (rsp_n1_out == 8'd1 || (rsp_n1_out != 8'd0 && !rsp_n1_out[0]))))
      else $error("bad dividers in an ok item");

   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !div_stat.done)
      else $error("divider finished right after start");
`endif

endmodule

/* rtl/dcods_div.sv */
// ----------------------------------------------------------------------------
// dcods_div
// Restoring divider, one quotient bit per cycle, sticky overflow flag.
// ----------------------------------------------------------------------------
module dcods_div import dcods_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output div_stat_type      stat,
   output logic [QUOT_W-1:0] quot
);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
         cnt_in  = CNT_W'(NUM_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         // a one leaving the top means the quotient does not fit
         ovf_in  = ovf_ff | quot_ff[QUOT_W-1];
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = ovf_ff;
   assign quot      = quot_ff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks dco_divider_search against a local model of the crystal derivation
// and the HS_DIV/N1 search. Targets go in through the request channel. Each
// response is compared field by field with the oldest queued prediction.
// Several factory settings are used, extremes included, and the sender and
// the receiver idle and stall in several patterns.
// ----------------------------------------------------------------------------
module testbench;
   import dcods_pkg::*;

   localparam int N1_MAX       = 128;
   localparam int DRAIN_CYCLES = 1000;
   localparam int CYCLE_LIMIT  = 12000000;

   typedef struct {
      status_type  status;
      logic [3:0]  hs_div;
      logic [7:0]  n1;
      logic [37:0] rfreq;
      logic [31:0] xtal;
      logic [47:0] image;
   } divider_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_index = CSR_FOUT;
   logic [47:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [30:0] req_target_hz = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_hs_div_out;
   logic [7:0]  rsp_n1_out;
   logic [37:0] rsp_rfreq_out;
   logic [31:0] rsp_xtal_hz;
   logic [47:0] rsp_reg_image;

   // local copy of the factory registers
   logic [30:0] fout_copy = FOUT_RESET;
   logic [47:0] regs_copy = '0;

   divider_result_type pending_results[$];
   int error_count = 0;
   int cycle_count = 0;

   // idle and stall rates in percent; hold_left forces a long receiver stall
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   dco_divider_search #(.N1_LIMIT(N1_MAX)) dut (
      .clock, .reset, .csr_write_en, .csr_index, .csr_wdata,
      .req_valid, .req_stall, .req_target_hz,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_hs_div_out, .rsp_n1_out,
      .rsp_rfreq_out, .rsp_xtal_hz, .rsp_reg_image
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: a forced hold-off wins, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // predicted response for one target under the current factory settings
   function automatic divider_result_type predict_dividers(logic [30:0] target);
      divider_result_type r;
      int unsigned hs_order[6] = '{11, 9, 7, 6, 5, 4};
      logic [7:0]   r7, r8;
      logic [63:0]  f_hs, f_n1, fdco, div, f, hs, n1, best, best_hs, best_n1, rf;
      logic [37:0]  f_rf;
      logic [127:0] quot;
      logic         found;
      r.status = STAT_OK;
      r.hs_div = '0;
      r.n1     = '0;
      r.rfreq  = '0;
      r.xtal   = '0;
      r.image  = '0;
      r7   = regs_copy[47:40];
      r8   = regs_copy[39:32];
      f_hs = 64'(r7[7:5]) + 64'd4;     // codes 4 and 6 give 8 and 10, no check
      f_n1 = 64'(r7[4:0]) * 64'd4 + 64'(r8[7:6]) + 64'd1;
      if (f_n1 > 64'd1) f_n1[0] = 1'b0;
      fdco = 64'(fout_copy) * f_n1 * f_hs;
      f_rf = regs_copy[37:0];
      quot = '0;
      // wide DCO values drop four RFREQ fraction bits
      if (fdco >= 64'd1 << 36) begin
         div = 64'(f_rf) >> 4;
         if (div != 0) quot = (128'(fdco) << 24) / 128'(div);
      end else if (f_rf != 0) begin
         quot = (128'(fdco) << 28) / 128'(f_rf);
      end
      r.xtal = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
      if (r.xtal == 0) begin
         r.status = STAT_ZERO_DIV;
         return r;
      end
      found   = 1'b0;
      best    = '0;
      best_hs = '0;
      best_n1 = '0;
      if (target != 0) begin
         foreach (hs_order[i]) begin
            hs = 64'(hs_order[i]);
            n1 = 64'd1;
            while (n1 <= 64'(N1_MAX)) begin
               f = 64'(target) * hs * n1;
               if (f > 64'(FDCO_HI)) break;
               // lowest DCO wins, first one found on a tie
               if (f >= 64'(FDCO_LO) && (!found || f < best)) begin
                  found   = 1'b1;
                  best    = f;
                  best_hs = hs;
                  best_n1 = n1;
               end
               n1 = n1 + ((n1 == 64'd1) ? 64'd1 : 64'd2);
            end
         end
      end
      if (!found) begin
         r.status = STAT_NO_DIV;
         return r;
      end
      r.hs_div = best_hs[3:0];
      r.n1     = best_n1[7:0];
      rf = (best << 28) / 64'(r.xtal);
      if (rf > 64'h3F_FFFF_FFFF) begin
         r.status = STAT_RF_OVF;
         return r;
      end
      r.rfreq = rf[37:0];
      best_n1 = best_n1 - 64'd1;
      r.image = {3'(best_hs - 64'd4), best_n1[6:2], best_n1[1:0], rf[37:0]};
      return r;
   endfunction

   // factory image whose RFREQ gives the wanted crystal from fout, HS and N1
   function automatic logic [47:0] factory_image(logic [30:0] fout, logic [2:0] hs_code,
                                                 logic [6:0] n1_code, logic [31:0] xtal);
      logic [63:0]  n1, fdco;
      logic [127:0] rf;
      n1 = 64'(n1_code) + 64'd1;
      if (n1 > 64'd1) n1[0] = 1'b0;
      fdco = 64'(fout) * n1 * (64'(hs_code) + 64'd4);
      rf = (128'(fdco) << 28) / 128'((xtal == 0) ? 32'd1 : xtal);
      return {hs_code, n1_code, rf[37:0]};
   endfunction

   // response checker
   always @(posedge clock) begin
      divider_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response with no item outstanding");
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               error_count++;
            end
            if (rsp_hs_div_out !== e.hs_div) begin
               $error("hs_div_out: expected %0d, got %0d", e.hs_div, rsp_hs_div_out);
               error_count++;
            end
            if (rsp_n1_out !== e.n1) begin
               $error("n1_out: expected %0d, got %0d", e.n1, rsp_n1_out);
               error_count++;
            end
            if (rsp_rfreq_out !== e.rfreq) begin
               $error("rfreq_out: expected %h, got %h", e.rfreq, rsp_rfreq_out);
               error_count++;
            end
            if (rsp_xtal_hz !== e.xtal) begin
               $error("xtal_hz: expected %0d, got %0d", e.xtal, rsp_xtal_hz);
               error_count++;
            end
            if (rsp_reg_image !== e.image) begin
               $error("reg_image: expected %h, got %h", e.image, rsp_reg_image);
               error_count++;
            end
         end
      end
   end

   // offer one item, wait for it to be taken, then maybe idle a while
   task automatic send_item(logic [30:0] target);
      req_valid     <= 1'b1;
      req_target_hz <= target;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_dividers(target));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // sender pause: every result back, then let the block settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // both registers, back to back; only called with the block drained
   task automatic set_factory(logic [30:0] fout, logic [47:0] regs);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_FOUT;
      csr_wdata    <= 48'(fout);
      @(posedge clock);
      fout_copy    = fout;
      csr_index    <= CSR_REGS;
      csr_wdata    <= regs;
      @(posedge clock);
      regs_copy    = regs;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [30:0] random_target();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return 31'($urandom_range(40000000, 1500000000));
         5, 6:          return 31'($urandom_range(1000000, 40000000));
         7:             return 31'($urandom_range(0, 1000));
         8:             return 31'($urandom_range(0, 1500000000));
         default:       return 31'(64'd4850000000 / 64'($urandom_range(4, 1408))
                                   + 64'($urandom_range(0, 2)) - 64'd1);
      endcase
   endfunction

   // ---- tests ----

   // reset values: RFREQ of zero means a zero divisor for every target
   task automatic test_reset_settings();
      send_item(31'd0);
      send_item(31'd156250000);
      send_item(31'd1500000000);
      wait_drained();
   endtask

   // field extremes and the ok and no-solution statuses under a typical part
   task automatic test_directed();
      set_factory(31'd156250000, factory_image(31'd156250000, 3'd0, 7'd7, 32'd114285000));
      send_item(31'd0);               // zero target, no solution
      send_item(31'd1);
      send_item(31'd3000000);         // too slow even at 11 * 128
      send_item(31'd10000000);
      send_item(31'd156250000);
      send_item(31'd1200000000);      // falls between the DCO bands
      send_item(31'd1417500000);      // top of the DCO window at HS 4
      send_item(31'd1212500000);      // bottom of the window
      send_item(31'd1500000000);
      send_item(31'd440909090);       // just below the bottom edge at HS 11
      send_item(31'd5000000);
      send_item(31'(1 << 30));
      wait_drained();
   endtask

   // odd HS codes, wide DCO path, saturation, zero crystal, RFREQ overflow
   task automatic test_factory_extremes();
      set_factory(31'd100000000, factory_image(31'd100000000, 3'd4, 7'd5, 32'd114285000));
      send_item(31'd200000000);
      wait_drained();
      set_factory(31'd150000000, factory_image(31'd150000000, 3'd6, 7'd0, 32'd100000000));
      send_item(31'd300000000);
      wait_drained();
      // fdco above 2^36
      set_factory(31'd1500000000, factory_image(31'd1500000000, 3'd7, 7'd127, 32'd114285000));
      send_item(31'd500000000);
      wait_drained();
      set_factory(31'h7FFFFFFF, 48'hFFFF_FFFF_FFFF);
      send_item(31'd700000000);
      wait_drained();
      // tiny RFREQ: crystal saturates
      set_factory(31'd156250000, {3'd0, 7'd7, 38'd1});
      send_item(31'd1000000000);
      wait_drained();
      // huge RFREQ: small crystal, new RFREQ overflows
      set_factory(31'd156250000, {3'd0, 7'd7, 38'h3F_FFFF_FFFF});
      send_item(31'd1400000000);
      send_item(31'd1250000000);
      wait_drained();
      // zero output frequency and a crystal that rounds to zero
      set_factory(31'd0, factory_image(31'd156250000, 3'd0, 7'd7, 32'd114285000));
      send_item(31'd500000000);
      wait_drained();
      set_factory(31'd1, {3'd0, 7'd0, 38'h3F_FFFF_FFFF});
      send_item(31'd500000000);
      wait_drained();
   endtask

   // random targets with one idle pattern and one factory setting
   task automatic test_random(int idle_pct, int stalling_pct, int count, int setting);
      logic [30:0] fout;
      logic [47:0] regs;
      fout = 31'($urandom_range(10000000, 1500000000));
      case (setting)
         0:       regs = factory_image(fout, 3'($urandom_range(0, 7)),
                                       7'($urandom), 32'($urandom_range(100000000, 120000000)));
         1:       regs = factory_image(fout, 3'($urandom_range(0, 7)),
                                       7'($urandom), 32'($urandom_range(1000000, 400000000)));
         2:       regs = factory_image(31'd156250000, 3'd1, 7'd5, 32'd114285000);
         default: regs = {16'($urandom), 32'($urandom)};
      endcase
      if (setting == 2) fout = 31'd156250000;
      set_factory(fout, regs);
      send_idle_pct = idle_pct;
      stall_pct     = stalling_pct;
      repeat (count) send_item(random_target());
      wait_drained();
   endtask

   // long receiver hold-off while the sender keeps offering
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left     = 5000;
      repeat (8) send_item(random_target());
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_directed();
      test_factory_extremes();
      test_random(0, 0, 440, 0);
      test_random(87, 0, 440, 1);
      test_random(0, 87, 440, 2);
      test_random(14, 14, 440, 3);
      test_backpressure();
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/dcods_pkg.sv
rtl/dcods_div.sv
rtl/dco_divider_search.sv
sim/testbench.sv
